### rtl/core/fwpf_pkg.sv
// ----------------------------------------------------------------------------
// fwpf_pkg
// Shared constants and types for the position-filter FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package fwpf_pkg;

    localparam int FWPF_DEPTH  = 64;
    localparam int FWPF_DATA_W = 32;

    // command codes
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_FILTER = 2'd2;

    // filter modes
    localparam logic [1:0] MODE_DROP_ODD  = 2'd0;
    localparam logic [1:0] MODE_DROP_EVEN = 2'd1;
    localparam logic [1:0] MODE_KEEP_3RD  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // per-cell control
    typedef struct packed {
        logic shift;   // take the neighbor's word
        logic wr;      // load the broadcast word (wins over shift)
    } t_cell_cmd;

endpackage

`default_nettype wire

### rtl/core/fwpf_cell.sv
// ----------------------------------------------------------------------------
// fwpf_cell
// One storage cell of the queue chain: holds one word, loads either the
// broadcast word or the word of the next cell toward the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module fwpf_cell
    import fwpf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire t_cell_cmd              i_cmd,
    input  wire logic [FWPF_DATA_W-1:0] i_nbr_data,
    input  wire logic [FWPF_DATA_W-1:0] i_wr_data,
    output logic      [FWPF_DATA_W-1:0] o_data
);

    logic [FWPF_DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_data <= i_wr_data;
        end else if (i_cmd.shift) begin
            r_data <= i_nbr_data;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/core/fifo_with_position_filter_unit.sv
// ----------------------------------------------------------------------------
// fifo_with_position_filter_unit
// Queue of signed 32-bit words with push, pop and a positional filter.
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH cells, cell 0 always holding the oldest word.
// For push, pop and an unused command the result is registered at the
// edge that takes the command. A filter on N held entries rotates the
// chain once per held entry, dropping or re-appending the head word at
// the tail, then writes its result once the output register is free. One
// command is in flight at a time; a new one is taken while a finished
// result waits only if that result is taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_position_filter_unit
    import fwpf_pkg::*;
#(
    parameter  int DEPTH = FWPF_DEPTH,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int OW    = ((FWPF_DATA_W + CW + 7) / 8) * 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // slave side
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [39:0]   s_axis_tdata,   // [31:0] push_value, [33:32] filter_mode
    input  wire logic [1:0]    s_axis_tuser,   // [1:0] command
    // master side
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [OW-1:0]      m_axis_tdata,   // [31:0] pop_value, [CW+31:32] fill_count
    output logic [1:0]         m_axis_tuser    // [1:0] status
);

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic                   w_in_xfer;
    logic [1:0]             w_cmd;
    logic [FWPF_DATA_W-1:0] w_push_val;
    logic [1:0]             w_mode;

    assign w_cmd      = s_axis_tuser;
    assign w_push_val = s_axis_tdata[FWPF_DATA_W-1:0];
    assign w_mode     = s_axis_tdata[FWPF_DATA_W+1:FWPF_DATA_W];

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic          r_busy,  n_busy;      // filter walk in progress
    logic [CW-1:0] r_cnt,   n_cnt;       // held entries (occupancy during walk)
    logic [CW-1:0] r_left,  n_left;      // entries still to visit
    logic          r_m2,    n_m2;        // position mod 2
    logic [1:0]    r_m3,    n_m3;        // position mod 3
    logic [1:0]    r_mode,  n_mode;

    // output register
    logic                   r_out_vld, n_out_vld;
    logic [FWPF_DATA_W-1:0] r_out_pop, n_out_pop;
    logic [1:0]             r_out_st,  n_out_st;
    logic [CW-1:0]          r_out_cnt, n_out_cnt;

    logic w_out_free;
    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_busy && w_out_free;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Filter step decision
    // ------------------------------------------------------------------
    logic w_step;        // one rotation of the walk this cycle
    logic w_keep;        // head word survives
    logic w_do_push;
    logic w_do_pop;

    assign w_step    = r_busy && (r_left != '0);
    assign w_do_push = w_in_xfer && (w_cmd == CMD_PUSH) && (r_cnt != CW'(DEPTH));
    assign w_do_pop  = w_in_xfer && (w_cmd == CMD_POP) && (r_cnt != '0);

    always_comb begin
        case (r_mode)
            MODE_DROP_ODD:  w_keep = !r_m2;
            MODE_DROP_EVEN: w_keep = r_m2;
            MODE_KEEP_3RD:  w_keep = (r_m3 == 2'd0);
            default:        w_keep = 1'b1;
        endcase
    end

    // tail slot for a re-appended word: occupancy after the head leaves
    logic [CW-1:0] w_tail;
    assign w_tail = r_cnt - CW'(1);

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    logic [FWPF_DATA_W-1:0] w_data [DEPTH];
    logic [FWPF_DATA_W-1:0] w_wr_data;

    // broadcast word: the head during a walk, the pushed word otherwise
    assign w_wr_data = r_busy ? w_data[0] : w_push_val;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_cell_cmd              w_ccmd;
        logic [FWPF_DATA_W-1:0] w_nbr;

        if (k == DEPTH - 1) begin : g_last
            assign w_nbr = '0;
        end else begin : g_mid
            assign w_nbr = w_data[k+1];
        end

        assign w_ccmd.shift = w_do_pop || w_step;
        assign w_ccmd.wr    = (w_do_push && (r_cnt == CW'(k)))
                           || (w_step && w_keep && (w_tail == CW'(k)));

        fwpf_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_ccmd),
            .i_nbr_data (w_nbr),
            .i_wr_data  (w_wr_data),
            .o_data     (w_data[k])
        );
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_busy    = r_busy;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_m2      = r_m2;
        n_m3      = r_m3;
        n_mode    = r_mode;
        n_out_vld = r_out_vld && !m_axis_tready;
        n_out_pop = r_out_pop;
        n_out_st  = r_out_st;
        n_out_cnt = r_out_cnt;

        if (w_in_xfer) begin
            n_out_pop = '0;
            n_out_st  = ST_OK;
            case (w_cmd)
                CMD_PUSH: begin
                    n_out_vld = 1'b1;
                    if (r_cnt == CW'(DEPTH)) begin
                        n_out_st = ST_FULL;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                    n_out_cnt = n_cnt;
                end
                CMD_POP: begin
                    n_out_vld = 1'b1;
                    if (r_cnt == '0) begin
                        n_out_st = ST_EMPTY;
                    end else begin
                        n_out_pop = w_data[0];
                        n_cnt     = r_cnt - CW'(1);
                    end
                    n_out_cnt = n_cnt;
                end
                CMD_FILTER: begin
                    n_busy = 1'b1;
                    n_left = r_cnt;
                    n_m2   = 1'b0;
                    n_m3   = 2'd0;
                    n_mode = w_mode;
                end
                default: begin
                    n_out_vld = 1'b1;
                    n_out_cnt = r_cnt;
                end
            endcase
        end else if (w_step) begin
            n_left = r_left - CW'(1);
            n_m2   = !r_m2;
            n_m3   = (r_m3 == 2'd2) ? 2'd0 : r_m3 + 2'd1;
            if (!w_keep) begin
                n_cnt = r_cnt - CW'(1);
            end
        end else if (r_busy && w_out_free) begin
            n_busy    = 1'b0;
            n_out_vld = 1'b1;
            n_out_pop = '0;
            n_out_st  = ST_OK;
            n_out_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left    <= n_left;
        r_m2      <= n_m2;
        r_m3      <= n_m3;
        r_mode    <= n_mode;
        r_out_pop <= n_out_pop;
        r_out_st  <= n_out_st;
        r_out_cnt <= n_out_cnt;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tdata  = {{(OW - FWPF_DATA_W - CW){1'b0}}, r_out_cnt, r_out_pop};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // occupancy never exceeds the chain length
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    // during a walk, unvisited entries are a subset of those held
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left <= r_cnt))
        else $error("filter walk overran occupancy");

    // a filter transfer starts a walk and blocks the input
    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (w_cmd == CMD_FILTER)) |=> (r_busy && !s_axis_tready))
        else $error("filter did not start a walk");

    // pop on an empty queue reports empty and keeps the queue empty
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (w_cmd == CMD_POP) && (r_cnt == '0))
            |=> (m_axis_tvalid && (r_out_st == ST_EMPTY) && (r_cnt == '0)))
        else $error("pop on empty mishandled");

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the position-filter FIFO.
// A queue of commands (push, pop, filter and the unused code) is built up front
// and streamed into the slave side with random idle bursts. Every accepted
// command is run through a shadow copy of the queue to form the expected
// result. Each master-side transfer is checked field by field against the
// oldest expected result. The receiver also holds off once for a long
// stretch so that results back up and the block stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import fwpf_pkg::*;

    localparam int FILL_W       = $clog2(FWPF_DEPTH + 1);
    localparam int RES_W        = ((FWPF_DATA_W + FILL_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1625;
    localparam int QUIET_ITEMS  = 120;    // tail of the run with no idling
    localparam int HOLD_AT      = 300;    // result count that starts the long hold
    localparam int HOLD_CYCLES  = 160;
    localparam int DRAIN_CYCLES = 100;    // settling time after the last result
    localparam int STALL_LIMIT  = 4000;   // cycles with no transfer on either side

    // codes the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // random segment shapes
    localparam int SEG_FILL   = 0;
    localparam int SEG_DRAIN  = 1;
    localparam int SEG_MIXED  = 2;
    localparam int SEG_FILTER = 3;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] word;
        logic [1:0]  mode;
    } t_queue_cmd;

    typedef struct {
        logic [31:0]       pop_value;
        logic [1:0]        status;
        logic [FILL_W-1:0] fill_count;
    } t_queue_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [39:0]      s_axis_tdata  = '0;   // [31:0] push_value, [33:32] filter_mode
    logic [1:0]       s_axis_tuser  = '0;   // [1:0] command
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [RES_W-1:0] m_axis_tdata;         // [31:0] pop_value, [38:32] fill_count
    logic [1:0]       m_axis_tuser;         // [1:0] status

    t_queue_cmd    pending_cmds[$];
    t_queue_result expected_results[$];
    logic [31:0]   shadow_words[$];         // held words, head first

    int fail_count    = 0;
    int total_items   = 0;
    int results_seen  = 0;

    fifo_with_position_filter_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow queue: applies one accepted command and queues its result.
    // ------------------------------------------------------------------------
    task automatic predict_queue_result(input logic [1:0] cmd, input logic [31:0] word,
                                        input logic [1:0] mode);
        t_queue_result res;
        logic [31:0]   survivors[$];
        bit            keep;
        res.pop_value = '0;
        res.status    = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (shadow_words.size() >= FWPF_DEPTH)
                    res.status = ST_FULL;   // word dropped, state unchanged
                else
                    shadow_words.push_back(word);
            end
            CMD_POP: begin
                if (shadow_words.size() == 0)
                    res.status = ST_EMPTY;
                else
                    res.pop_value = shadow_words.pop_front();
            end
            CMD_FILTER: begin
                // positions count from the head, starting at 0
                foreach (shadow_words[i]) begin
                    case (mode)
                        MODE_DROP_ODD:  keep = (i % 2) == 0;
                        MODE_DROP_EVEN: keep = (i % 2) == 1;
                        MODE_KEEP_3RD:  keep = (i % 3) == 0;
                        default:        keep = 1'b1;   // unused mode removes nothing
                    endcase
                    if (keep)
                        survivors.push_back(shadow_words[i]);
                end
                shadow_words = survivors;
            end
            default: ;                      // unused command: no change
        endcase
        res.fill_count = FILL_W'(shadow_words.size());
        expected_results.push_back(res);
    endtask

    task automatic add_cmd(input logic [1:0] cmd, input logic [31:0] word,
                           input logic [1:0] mode);
        t_queue_cmd c;
        c.cmd  = cmd;
        c.word = word;
        c.mode = mode;
        pending_cmds.push_back(c);
    endtask

    // ------------------------------------------------------------------------
    // Driver: slave side. Predicts on each accepted transfer, then loads the
    // next command unless an idle burst is running.
    // ------------------------------------------------------------------------
    t_queue_cmd drive_item;
    int         send_gap = 0;
    int         send_run = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
            send_run = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_queue_result(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[33:32]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    drive_item = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, drive_item.mode, drive_item.word};
                    s_axis_tuser  <= drive_item.cmd;
                    // idle bursts only outside the quiet tail
                    if (pending_cmds.size() > QUIET_ITEMS) begin
                        if (send_run > 0) begin
                            send_run = send_run - 1;
                        end else begin
                            send_gap = $urandom_range(1, 7);
                            send_run = $urandom_range(0, 30);
                        end
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: master side. Checks each transfer against the oldest
    // expectation and drives tready with stall bursts and one long hold.
    // ------------------------------------------------------------------------
    t_queue_result want;
    int            hold_left  = 0;
    bit            hold_done  = 1'b0;
    int            stall_left = 0;
    int            take_run   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen = results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[31:0] !== want.pop_value) begin
                        $error("pop_value mismatch: expected %0d, got %0d",
                               $signed(want.pop_value), $signed(m_axis_tdata[31:0]));
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[FILL_W+31:32] !== want.fill_count) begin
                        $error("fill_count mismatch: expected %0d, got %0d",
                               want.fill_count, m_axis_tdata[FILL_W+31:32]);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                // long back-pressure: sender keeps offering, block must stall
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (results_seen + QUIET_ITEMS < total_items) begin
                    if (take_run > 0) begin
                        take_run = take_run - 1;
                    end else begin
                        stall_left = $urandom_range(1, 7);
                        take_run   = $urandom_range(0, 30);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no transfer happens for too long.
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("fifo_with_position_filter_unit regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int          counted;
        int          seg_kind;
        int          seg_len;
        int          pick;
        int          push_lim;
        int          pop_lim;
        int          filt_lim;
        logic [1:0]  cmd;
        logic [31:0] word;

        // directed: empty-queue corners, unused codes, extreme words, each mode
        add_cmd(CMD_POP,    32'h0000_0000, MODE_DROP_ODD);   // pop on empty
        add_cmd(CMD_FILTER, 32'h0000_0000, MODE_DROP_ODD);   // filter on empty
        add_cmd(CMD_UNUSED, 32'hFFFF_FFFF, MODE_UNUSED);     // ignored command
        add_cmd(CMD_PUSH,   32'h7FFF_FFFF, MODE_DROP_ODD);
        add_cmd(CMD_PUSH,   32'h8000_0000, MODE_DROP_EVEN);
        add_cmd(CMD_PUSH,   32'h0000_0000, MODE_KEEP_3RD);
        add_cmd(CMD_PUSH,   32'hFFFF_FFFF, MODE_UNUSED);
        add_cmd(CMD_PUSH,   32'h5555_5555, MODE_DROP_ODD);
        add_cmd(CMD_PUSH,   32'hAAAA_AAAA, MODE_DROP_ODD);
        add_cmd(CMD_PUSH,   32'h0000_0001, MODE_DROP_ODD);
        add_cmd(CMD_FILTER, 32'h1234_5678, MODE_UNUSED);     // removes nothing
        add_cmd(CMD_FILTER, 32'h0000_0000, MODE_DROP_EVEN);
        add_cmd(CMD_PUSH,   32'h1234_5678, MODE_DROP_ODD);
        add_cmd(CMD_PUSH,   32'hDEAD_BEEF, MODE_DROP_ODD);
        add_cmd(CMD_PUSH,   32'h0F0F_0F0F, MODE_DROP_ODD);
        add_cmd(CMD_FILTER, 32'h0000_0000, MODE_KEEP_3RD);
        add_cmd(CMD_PUSH,   32'hF0F0_F0F0, MODE_DROP_ODD);
        add_cmd(CMD_PUSH,   32'h8000_0001, MODE_DROP_ODD);
        add_cmd(CMD_FILTER, 32'h0000_0000, MODE_DROP_ODD);
        add_cmd(CMD_POP,    32'h0000_0000, MODE_DROP_ODD);
        add_cmd(CMD_POP,    32'h0000_0000, MODE_DROP_ODD);   // last entry out
        add_cmd(CMD_POP,    32'h0000_0000, MODE_DROP_ODD);   // empty again
        add_cmd(CMD_PUSH,   32'hCAFE_F00D, MODE_DROP_ODD);
        add_cmd(CMD_POP,    32'h0000_0000, MODE_DROP_ODD);

        // random: segments of fill, drain, mixed and filter-heavy traffic
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            seg_kind = $urandom_range(SEG_FILL, SEG_FILTER);
            seg_len  = (seg_kind == SEG_FILL) ? $urandom_range(66, 90) : $urandom_range(20, 60);
            case (seg_kind)
                SEG_FILL:  begin push_lim = 92; pop_lim = 95; filt_lim = 97; end
                SEG_DRAIN: begin push_lim = 15; pop_lim = 85; filt_lim = 95; end
                SEG_MIXED: begin push_lim = 45; pop_lim = 80; filt_lim = 95; end
                default:   begin push_lim = 55; pop_lim = 65; filt_lim = 95; end
            endcase
            repeat (seg_len) begin
                pick = $urandom_range(0, 99);
                cmd  = (pick < push_lim) ? CMD_PUSH :
                       (pick < pop_lim)  ? CMD_POP  :
                       (pick < filt_lim) ? CMD_FILTER : CMD_UNUSED;
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       word = 32'h8000_0000;
                        1:       word = 32'h7FFF_FFFF;
                        2:       word = 32'hFFFF_FFFF;
                        default: word = 32'h0000_0000;
                    endcase
                end else begin
                    word = $urandom();
                end
                add_cmd(cmd, word, 2'($urandom_range(0, 3)));
                counted++;
            end
        end
        total_items = pending_cmds.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all commands taken, every result back, then let the block settle
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("fifo_with_position_filter_unit regression: pass");
        else
            $display("fifo_with_position_filter_unit regression: fail");
        $finish;
    end

endmodule
